// ----- hdl/ddwf_pkg.sv -----
// Package for the depth discontinuity window filter.
// Field widths, payload and control structs, register indexes and reset values.
// No dependencies.
package ddwf_pkg;

   localparam int DEPTH_W  = 16;
   localparam int DIM_W    = 11;
   localparam int SCALE_W  = 24;
   localparam int COEF_W   = 16;
   localparam int CNT_W    = 22;
   localparam int WSUM_W   = 37;
   localparam int ZSUM_W   = 53;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST   = 11'd640;
   localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST  = 11'd480;
   localparam logic [SCALE_W-1:0] DISC_SCALE_RST    = 24'd8389;
   localparam logic [COEF_W-1:0]  WEIGHT_CENTER_RST = 16'd65535;
   localparam logic [COEF_W-1:0]  WEIGHT_ONE_RST    = 16'd39750;
   localparam logic [COEF_W-1:0]  WEIGHT_TWO_RST    = 16'd8869;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_DISC_SCALE    = 3'd2,
      CSR_WEIGHT_CENTER = 3'd3,
      CSR_WEIGHT_ONE    = 3'd4,
      CSR_WEIGHT_TWO    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               cmd;
      logic [DEPTH_W-1:0] depth_in;
   } req_payload_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_out;
      logic               frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic centre_issue;
      logic raster_issue;
      logic div_start;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic go;
      logic pipe_busy;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hdl/ddwf_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is set by the instantiating level.
interface ddwf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/depth_discontinuity_window_filter.sv -----
// Depth discontinuity aware window filter. A transaction that yields no result
// (a pixel still filling the window, or an ignored flush) returns from the check
// state to idle. One that yields a result reads the window one pixel a cycle
// from the line store through a 6-stage weight and discontinuity pipeline,
// then a 16-step divider forms the mean. The output register lets the next
// transaction in while a result waits.
// The line store holds 2^ceil(log2(4*RADIUS*MAX_WIDTH/2+2*RADIUS+1)) pixels and
// needs no clearing after reset.
module depth_discontinuity_window_filter #(
   parameter int RADIUS    = 2,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ddwf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ddwf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   ddwf_stream_if.sink                       req_if,
   ddwf_stream_if.source                     rsp_if
);
   ddwf_pkg::dp_cmd_type      cmd;
   ddwf_pkg::dp_status_type   status;
   ddwf_pkg::req_payload_type req_data;
   ddwf_pkg::rsp_payload_type rsp_data;
   logic                      req_ready;
   logic                      rsp_valid;

   assign req_data       = req_if.payload;
   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_data;

   ddwf_ctrl #(
      .SPAN (2 * RADIUS + 1)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddwf_dp #(
      .RADIUS    (RADIUS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- hdl/ddwf_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient known to fit DEPTH_W bits.
// Uses ddwf_pkg widths.
module ddwf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ddwf_pkg::ZSUM_W-1:0]  dividend,
   input  logic [ddwf_pkg::WSUM_W-1:0]  divisor,
   output logic                         done,
   output logic [ddwf_pkg::DEPTH_W-1:0] quotient
);
   localparam int QW = ddwf_pkg::DEPTH_W;
   localparam int BW = $clog2(QW);

   logic [ddwf_pkg::ZSUM_W-1:0] rem_ff;
   logic [ddwf_pkg::WSUM_W-1:0] den_ff;
   logic [QW-1:0]               q_ff;
   logic [BW-1:0]               bit_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [ddwf_pkg::ZSUM_W-1:0] shifted;
   logic                        ge;

   assign shifted  = ddwf_pkg::ZSUM_W'(den_ff) << bit_ff;
   assign ge       = rem_ff >= shifted;
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         den_ff <= divisor;
         q_ff   <= '0;
         bit_ff <= BW'(QW - 1);
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff       <= rem_ff - shifted;
            q_ff[bit_ff] <= 1'b1;
         end
         if (bit_ff != '0) begin
            bit_ff <= bit_ff - 1'b1;
         end
      end
   end
endmodule

// ----- hdl/ddwf_dp.sv -----
// Datapath: config registers, frame counters, line store, window pipeline,
// accumulators, divider and output register. Uses ddwf_pkg and ddwf_div.
module ddwf_dp #(
   parameter int RADIUS    = 2,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ddwf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ddwf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  ddwf_pkg::req_payload_type        req_data,
   input  ddwf_pkg::dp_cmd_type             cmd,
   output ddwf_pkg::dp_status_type          status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ddwf_pkg::rsp_payload_type        rsp_data
);
   localparam int SPAN        = 2 * RADIUS + 1;
   localparam int GW          = $clog2(SPAN);
   localparam int STORE_DEPTH = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int MEM_DEPTH   = 1 << AW;
   localparam int DW          = ddwf_pkg::DEPTH_W;
   localparam int NW          = ddwf_pkg::DIM_W;
   localparam int CW          = ddwf_pkg::CNT_W;

   // configuration
   logic [NW-1:0]                    fw_ff, fh_ff;
   logic [ddwf_pkg::SCALE_W-1:0]     ds_ff;
   logic [ddwf_pkg::COEF_W-1:0]      wc_ff, w1_ff, w2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= ddwf_pkg::FRAME_WIDTH_RST;
         fh_ff <= ddwf_pkg::FRAME_HEIGHT_RST;
         ds_ff <= ddwf_pkg::DISC_SCALE_RST;
         wc_ff <= ddwf_pkg::WEIGHT_CENTER_RST;
         w1_ff <= ddwf_pkg::WEIGHT_ONE_RST;
         w2_ff <= ddwf_pkg::WEIGHT_TWO_RST;
      end else if (csr_we) begin
         case (csr_index)
            ddwf_pkg::CSR_FRAME_WIDTH:   fw_ff <= csr_wdata[NW-1:0];
            ddwf_pkg::CSR_FRAME_HEIGHT:  fh_ff <= csr_wdata[NW-1:0];
            ddwf_pkg::CSR_DISC_SCALE:    ds_ff <= csr_wdata;
            ddwf_pkg::CSR_WEIGHT_CENTER: wc_ff <= csr_wdata[15:0];
            ddwf_pkg::CSR_WEIGHT_ONE:    w1_ff <= csr_wdata[15:0];
            ddwf_pkg::CSR_WEIGHT_TWO:    w2_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // frame position
   logic [NW-1:0] lat_w_ff, lat_h_ff;
   logic [NW-1:0] in_col_ff, in_row_ff, out_col_ff, out_row_ff;
   logic [CW-1:0] in_idx_ff, out_cnt_ff;
   logic [NW-1:0] pos_row_ff, pos_col_ff;
   logic          last_ff, go_ff;

   logic          idle, start_frame, arriving, write_px, emit, out_last;
   logic [NW-1:0] fw_clamp, fh_clamp, lw, lh;
   logic [CW-1:0] total, delay;

   always_comb begin
      idle = in_row_ff == '0 && in_col_ff == '0 && out_cnt_ff == '0;
      if (fw_ff == '0) begin
         fw_clamp = NW'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         fw_clamp = NW'(MAX_WIDTH);
      end else begin
         fw_clamp = fw_ff;
      end
      fh_clamp    = (fh_ff == '0) ? NW'(1) : fh_ff;
      start_frame = idle && !req_data.cmd;
      lw          = start_frame ? fw_clamp : lat_w_ff;
      lh          = start_frame ? fh_clamp : lat_h_ff;
      total       = {11'b0, lw} * {11'b0, lh};
      delay       = {11'b0, lw} * CW'(RADIUS) + CW'(RADIUS);
      arriving    = in_row_ff < lh;
      write_px    = cmd.accept && arriving && !req_data.cmd;
      if (arriving) begin
         emit = !req_data.cmd && in_idx_ff >= delay && out_cnt_ff < total;
      end else begin
         emit = out_cnt_ff < total;
      end
      out_last = (out_cnt_ff + CW'(1)) == total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_w_ff   <= ddwf_pkg::FRAME_WIDTH_RST;
         lat_h_ff   <= ddwf_pkg::FRAME_HEIGHT_RST;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_idx_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_cnt_ff <= '0;
         go_ff      <= 1'b0;
      end else begin
         go_ff <= cmd.accept && emit;
         if (cmd.accept) begin
            if (start_frame) begin
               lat_w_ff <= lw;
               lat_h_ff <= lh;
            end
            if (write_px) begin
               in_idx_ff <= in_idx_ff + CW'(1);
               if (in_col_ff + NW'(1) >= lw) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + NW'(1);
               end else begin
                  in_col_ff <= in_col_ff + NW'(1);
               end
            end
            if (emit) begin
               out_cnt_ff <= out_cnt_ff + CW'(1);
               if (out_col_ff + NW'(1) >= lw) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + NW'(1);
               end else begin
                  out_col_ff <= out_col_ff + NW'(1);
               end
               if (out_last) begin
                  in_col_ff  <= '0;
                  in_row_ff  <= '0;
                  in_idx_ff  <= '0;
                  out_col_ff <= '0;
                  out_row_ff <= '0;
                  out_cnt_ff <= '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emit) begin
         pos_row_ff <= out_row_ff;
         pos_col_ff <= out_col_ff;
         last_ff    <= out_last;
      end
   end

   // line store
   logic [DW-1:0] mem [MEM_DEPTH];
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] rd2_ff;

   always_ff @(posedge clock) begin
      if (write_px) begin
         mem[in_idx_ff[AW-1:0]] <= req_data.depth_in;
      end
      rd2_ff <= mem[rd_addr];
   end

   // window walk
   logic [GW-1:0] gi_ff, gj_ff, ei, ej;
   logic          issue, skip0;
   logic [13:0]   row_s, col_s;
   logic [NW-1:0] r0, c0;
   logic [1:0]    ai, aj;

   function automatic logic [15:0] coef_of(input logic [1:0] a,
                                           input logic [15:0] c0v,
                                           input logic [15:0] c1v,
                                           input logic [15:0] c2v);
      case (a)
         2'd0:    coef_of = c0v;
         2'd1:    coef_of = c1v;
         default: coef_of = c2v;
      endcase
   endfunction

   always_comb begin
      issue = cmd.centre_issue || cmd.raster_issue;
      ei    = cmd.centre_issue ? GW'(RADIUS) : gi_ff;
      ej    = cmd.centre_issue ? GW'(RADIUS) : gj_ff;
      skip0 = cmd.raster_issue && ei == GW'(RADIUS) && ej == GW'(RADIUS);
      ai    = 2'((ei >= GW'(RADIUS)) ? ei - GW'(RADIUS) : GW'(RADIUS) - ei);
      aj    = 2'((ej >= GW'(RADIUS)) ? ej - GW'(RADIUS) : GW'(RADIUS) - ej);
      row_s = {3'b0, pos_row_ff} + 14'(ei) - 14'(RADIUS);
      col_s = {3'b0, pos_col_ff} + 14'(ej) - 14'(RADIUS);
      if (row_s[13]) begin
         r0 = '0;
      end else if (row_s > {3'b0, lat_h_ff - NW'(1)}) begin
         r0 = lat_h_ff - NW'(1);
      end else begin
         r0 = row_s[NW-1:0];
      end
      if (col_s[13]) begin
         c0 = '0;
      end else if (col_s > {3'b0, lat_w_ff - NW'(1)}) begin
         c0 = lat_w_ff - NW'(1);
      end else begin
         c0 = col_s[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.centre_issue) begin
         gi_ff <= '0;
         gj_ff <= '0;
      end else if (cmd.raster_issue) begin
         if (gj_ff == GW'(SPAN - 1)) begin
            gj_ff <= '0;
            gi_ff <= gi_ff + GW'(1);
         end else begin
            gj_ff <= gj_ff + GW'(1);
         end
      end
   end

   // pipeline: s1 address, s2 read data, s3 base, s4 products, s5 square, s6 decision
   logic [6:1]    v_ff;
   logic [NW-1:0] r1_ff, c1_ff;
   logic [1:0]    ai1_ff, aj1_ff;
   logic [6:1]    force_ff, skip_ff;
   logic [3:0]    du2_2_ff, du2_3_ff, du2_4_ff, du2_5_ff;
   logic [31:0]   w2_p_ff, w3_ff, w4_ff, w5_ff, w6_ff;
   logic [DW-1:0] centre_ff, d3_ff;
   logic [39:0]   base3_ff, hh4_ff, hl4_ff, ll4_ff;
   logic [DW-1:0] gap3_ff;
   logic [31:0]   gsq4_ff, gsq5_ff;
   logic [47:0]   wd4_ff, wd5_ff, wd6_ff;
   logic          zero4_ff, zero5_ff, take6_ff;
   logic [79:0]   base2_5_ff;

   logic [CW-1:0] addr_full;
   logic [31:0]   wprod;
   logic [DW-1:0] cen, lo_d, gap;
   logic [39:0]   base, hh, hl, ll;
   logic [19:0]   bh, bl;
   logic [31:0]   gsq;
   logic [47:0]   wd;
   logic [79:0]   base2;
   logic [83:0]   rhs, lhs;
   logic          disc, take;

   always_comb begin
      addr_full = {11'b0, r1_ff} * {11'b0, lat_w_ff} + {11'b0, c1_ff};
      rd_addr   = addr_full[AW-1:0];
      wprod     = {16'b0, coef_of(ai1_ff, wc_ff, w1_ff, w2_ff)}
                * {16'b0, coef_of(aj1_ff, wc_ff, w1_ff, w2_ff)};
      cen       = force_ff[2] ? rd2_ff : centre_ff;
      lo_d      = (cen < rd2_ff) ? cen : rd2_ff;
      gap       = ((cen < rd2_ff) ? rd2_ff : cen) - lo_d;
      base      = {24'b0, lo_d} * {16'b0, ds_ff};
      bh        = base3_ff[39:20];
      bl        = base3_ff[19:0];
      hh        = {20'b0, bh} * {20'b0, bh};
      hl        = {20'b0, bh} * {20'b0, bl};
      ll        = {20'b0, bl} * {20'b0, bl};
      gsq       = {16'b0, gap3_ff} * {16'b0, gap3_ff};
      wd        = {16'b0, w3_ff} * {32'b0, d3_ff};
      base2     = {hh4_ff, 40'b0} + {19'b0, hl4_ff, 21'b0} + {40'b0, ll4_ff};
      rhs       = (du2_5_ff[0] ? {4'b0, base2_5_ff}       : 84'b0)
                + (du2_5_ff[1] ? {3'b0, base2_5_ff, 1'b0} : 84'b0)
                + (du2_5_ff[2] ? {2'b0, base2_5_ff, 2'b0} : 84'b0)
                + (du2_5_ff[3] ? {1'b0, base2_5_ff, 3'b0} : 84'b0);
      lhs       = {4'b0, gsq5_ff, 48'b0};
      disc      = lhs > rhs;
      take      = force_ff[5] || (!skip_ff[5] && !zero5_ff && !disc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:1], issue};
      end
   end

   always_ff @(posedge clock) begin
      force_ff   <= {force_ff[5:1], cmd.centre_issue};
      skip_ff    <= {skip_ff[5:1], skip0};
      r1_ff      <= r0;
      c1_ff      <= c0;
      ai1_ff     <= ai;
      aj1_ff     <= aj;
      du2_2_ff   <= 4'({2'b0, ai1_ff} * {2'b0, ai1_ff} + {2'b0, aj1_ff} * {2'b0, aj1_ff});
      w2_p_ff    <= wprod;
      base3_ff   <= base;
      gap3_ff    <= gap;
      w3_ff      <= w2_p_ff;
      d3_ff      <= rd2_ff;
      du2_3_ff   <= du2_2_ff;
      hh4_ff     <= hh;
      hl4_ff     <= hl;
      ll4_ff     <= ll;
      gsq4_ff    <= gsq;
      wd4_ff     <= wd;
      w4_ff      <= w3_ff;
      du2_4_ff   <= du2_3_ff;
      zero4_ff   <= d3_ff == '0;
      base2_5_ff <= base2;
      gsq5_ff    <= gsq4_ff;
      wd5_ff     <= wd4_ff;
      w5_ff      <= w4_ff;
      du2_5_ff   <= du2_4_ff;
      zero5_ff   <= zero4_ff;
      take6_ff   <= take;
      w6_ff      <= w5_ff;
      wd6_ff     <= wd5_ff;
      if (v_ff[2] && force_ff[2]) begin
         centre_ff <= rd2_ff;
      end
   end

   // accumulation
   logic [ddwf_pkg::WSUM_W-1:0] wsum_ff;
   logic [ddwf_pkg::ZSUM_W-1:0] zsum_ff;

   always_ff @(posedge clock) begin
      if (cmd.centre_issue) begin
         wsum_ff <= '0;
         zsum_ff <= '0;
      end else if (v_ff[6] && take6_ff) begin
         wsum_ff <= wsum_ff + {5'b0, w6_ff};
         zsum_ff <= zsum_ff + {5'b0, wd6_ff};
      end
   end

   logic          div_done;
   logic [DW-1:0] quotient;

   ddwf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (zsum_ff),
      .divisor  (wsum_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // output register
   logic                      rsp_valid_ff;
   ddwf_pkg::rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.depth_out  <= (wsum_ff == '0) ? centre_ff : quotient;
         rsp_data_ff.frame_last <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.go        = go_ff;
   assign status.pipe_busy = |v_ff;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   a_div_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> v_ff == '0)
      else $error("divide started with window pipeline busy");

   a_idx_consistent: assert property (@(posedge clock) disable iff (reset)
      in_idx_ff == ({11'b0, in_row_ff} * {11'b0, lat_w_ff} + {11'b0, in_col_ff}))
      else $error("raster index out of step with row and column");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("response raised without load");
endmodule

// ----- hdl/ddwf_ctrl.sv -----
// Controller state machine: accept, window walk, drain, divide, output load.
// Uses ddwf_pkg command and status structs.
module ddwf_ctrl #(
   parameter int SPAN = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ddwf_pkg::dp_status_type  status,
   output ddwf_pkg::dp_cmd_type     cmd
);
   localparam int NI = SPAN * SPAN;
   localparam int CW = $clog2(NI + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_GATHER,
      S_DRAIN,
      S_DIV,
      S_OUT
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;

   always_comb begin
      req_ready        = state_ff == S_IDLE;
      cmd.accept       = req_ready && req_valid;
      cmd.centre_issue = state_ff == S_GATHER && cnt_ff == '0;
      cmd.raster_issue = state_ff == S_GATHER && cnt_ff != '0;
      cmd.div_start    = state_ff == S_DRAIN && !status.pipe_busy;
      cmd.out_load     = state_ff == S_OUT && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               cnt_ff   <= '0;
               state_ff <= status.go ? S_GATHER : S_IDLE;
            end
            S_GATHER: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(NI)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!status.pipe_busy) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (status.div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
